// ===== hw/rtl/pbt_pkg.sv =====
package pbt_pkg;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_SET    = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_PLAYING = 2'd1;
  localparam logic [1:0] RUN_INVALID = 2'd3;

  localparam logic [1:0] MODE_ONCE = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  localparam logic [15:0] RATE_ONE = 16'h0100;
  localparam int          RESULT_CAP = 64;

  typedef struct packed {
    logic [31:0] tm;
    logic [15:0] rate;
    logic [1:0]  run;
    logic [1:0]  mode;
    logic [31:0] len;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MRD,
    S_MWR,
    S_TRD,
    S_TMUL,
    S_TADD,
    S_TREM,
    S_TWB
  } state_e;

endpackage

// ===== hw/rtl/pbt_mem.sv =====
module pbt_mem import pbt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/pbt_rem.sv =====
module pbt_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [32:0] rem_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dq_q, dq_d;
  logic [32:0] div_q, div_d;
  logic [32:0] r_q, r_d;
  logic        done_q, done_d;
  logic [33:0] shifted;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    div_d   = div_q;
    r_d     = r_q;
    done_d  = 1'b0;
    shifted = {r_q, dq_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      div_d  = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, div_q}) begin
        r_d = 33'(shifted - {1'b0, div_q});
      end else begin
        r_d = shifted[32:0];
      end
      dq_d  = {dq_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    div_q <= div_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ===== hw/rtl/playback_timeline_table.sv =====
// Playback timeline table: a dense list of up to MAX_ENTRIES timelines.
// Input channel: in_valid_i / in_stall_o with kind_i and the request fields.
// Output channel: out_valid_o / out_stall_i with status, slot, time, state
// and last. Add, remove, set and clear give one result each, tick gives
// one per entry (at most 64); an empty table and other kind codes give none.
// Add, set, clear and failing requests are done when accepted and their
// result appears in the output register on the next cycle. Remove then
// copies the last entry into the hole unless the hole was the last slot.
// Tick walks the entries one at a time: read, multiply, add, then a
// bit-serial remainder for a playing entry of nonzero length in ping-pong
// mode, or in loop mode once it passes its end, then write back, which
// waits while the receiver stalls a result within the first 64 entries.
// Entries live in one memory with a registered synchronous read; the entry
// count is a register and reset clears it, the memory needs no clearing.
// A stalled result holds in the output register; new requests and further
// tick results wait until it is taken.
module playback_timeline_table import pbt_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  index_i,
  input  logic [19:0] dt_i,
  input  logic [31:0] local_time_i,
  input  logic [15:0] time_scale_i,
  input  logic [1:0]  run_state_i,
  input  logic [1:0]  loop_mode_i,
  input  logic [31:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] time_out_o,
  output logic [1:0]  state_out_o,
  output logic        last_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [XW-1:0] nlast_q, nlast_d;
  logic [19:0]   dt_q, dt_d;
  entry_t        ent_q, ent_d;
  logic [35:0]   prod_q, prod_d;
  logic [31:0]   tnew_q, tnew_d;
  logic [1:0]    runnew_q, runnew_d;

  logic          ov_q, ov_d;
  logic [1:0]    status_q, status_d;
  logic [5:0]    slot_q, slot_d;
  logic [31:0]   time_q, time_d;
  logic [1:0]    sout_q, sout_d;
  logic          last_q, last_d;

  logic          can_load, acc;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          rem_start, rem_done;
  logic [31:0]   rem_dividend;
  logic [32:0]   rem_divisor, rem_res;

  logic [XW-1:0] idx_x, cnt_x, ptr_x;
  logic [32:0]   sum, len33, two;
  logic [31:0]   tsat;
  logic [1:0]    run_w;

  pbt_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pbt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .done_o     (rem_done),
    .rem_o      (rem_res)
  );

  assign can_load   = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && can_load);
  assign acc        = in_valid_i && !in_stall_o;

  assign idx_x = XW'(index_i);
  assign cnt_x = XW'(count_q);
  assign ptr_x = XW'(ptr_q);
  assign sum   = {1'b0, ent_q.tm} + 33'(prod_q[35:8]);
  assign tsat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign len33 = {1'b0, ent_q.len};
  assign two   = {ent_q.len, 1'b0};
  assign run_w = (run_state_i == RUN_INVALID) ? RUN_STOPPED : run_state_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    nlast_d      = nlast_q;
    dt_d         = dt_q;
    ent_d        = ent_q;
    prod_d       = prod_q;
    tnew_d       = tnew_q;
    runnew_d     = runnew_q;
    ov_d         = ov_q && out_stall_i;
    status_d     = status_q;
    slot_d       = slot_q;
    time_d       = time_q;
    sout_d       = sout_q;
    last_d       = last_q;
    we           = 1'b0;
    waddr        = ptr_q;
    wdata        = ent_q;
    raddr        = ptr_q;
    rem_start    = 1'b0;
    rem_dividend = tsat;
    rem_divisor  = len33;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          status_d = ST_OK;
          slot_d   = '0;
          time_d   = '0;
          sout_d   = RUN_STOPPED;
          last_d   = 1'b1;
          unique case (kind_i)
            KIND_ADD: begin
              ov_d = 1'b1;
              if (count_q == CW'(MAX_ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count_q[AW-1:0];
                wdata.tm   = '0;
                wdata.rate = RATE_ONE;
                wdata.run  = RUN_PLAYING;
                wdata.mode = MODE_LOOP;
                wdata.len  = duration_i;
                slot_d     = cnt_x[5:0];
                sout_d     = RUN_PLAYING;
                count_d    = count_q + CW'(1);
              end
            end
            KIND_REMOVE: begin
              ov_d   = 1'b1;
              slot_d = index_i;
              if (idx_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                ptr_d   = idx_x[AW-1:0];
                if (idx_x < cnt_x - XW'(1)) begin
                  state_d = S_MRD;
                end
              end
            end
            KIND_SET: begin
              ov_d   = 1'b1;
              slot_d = index_i;
              if (idx_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                we         = 1'b1;
                waddr      = idx_x[AW-1:0];
                wdata.tm   = local_time_i;
                wdata.rate = time_scale_i;
                wdata.run  = run_w;
                wdata.mode = loop_mode_i;
                wdata.len  = duration_i;
                time_d     = local_time_i;
                sout_d     = run_w;
              end
            end
            KIND_TICK: begin
              if (count_q != '0) begin
                dt_d    = dt_i;
                ptr_d   = '0;
                nlast_d = (cnt_x > XW'(RESULT_CAP)) ? XW'(RESULT_CAP - 1)
                                                    : cnt_x - XW'(1);
                state_d = S_TRD;
              end
            end
            KIND_CLEAR: begin
              ov_d    = 1'b1;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MRD: begin
        // count already points at the old last entry
        raddr   = count_q[AW-1:0];
        state_d = S_MWR;
      end
      S_MWR: begin
        we      = 1'b1;
        waddr   = ptr_q;
        wdata   = rdata;
        state_d = S_IDLE;
      end
      S_TRD: begin
        raddr   = ptr_q;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        ent_d   = rdata;
        prod_d  = dt_q * rdata.rate;
        state_d = S_TADD;
      end
      S_TADD: begin
        tnew_d   = ent_q.tm;
        runnew_d = ent_q.run;
        state_d  = S_TWB;
        if (ent_q.run == RUN_PLAYING) begin
          tnew_d = tsat;
          if (ent_q.len != '0) begin
            if (ent_q.mode == MODE_ONCE) begin
              if ({1'b0, tsat} >= len33) begin
                tnew_d   = ent_q.len;
                runnew_d = RUN_STOPPED;
              end
            end else if (ent_q.mode == MODE_LOOP) begin
              if ({1'b0, tsat} >= len33) begin
                rem_start = 1'b1;
                state_d   = S_TREM;
              end
            end else if (ent_q.mode == MODE_PING) begin
              rem_divisor = two;
              rem_start   = 1'b1;
              state_d     = S_TREM;
            end
          end
        end
      end
      S_TREM: begin
        if (rem_done) begin
          // ping-pong folds the upper half back down
          if (ent_q.mode == MODE_PING && rem_res >= len33) begin
            tnew_d = 32'(two - rem_res);
          end else begin
            tnew_d = rem_res[31:0];
          end
          state_d = S_TWB;
        end
      end
      S_TWB: begin
        if (ptr_x >= XW'(RESULT_CAP) || can_load) begin
          we         = 1'b1;
          waddr      = ptr_q;
          wdata.tm   = tnew_q;
          wdata.run  = runnew_q;
          if (ptr_x < XW'(RESULT_CAP)) begin
            ov_d     = 1'b1;
            status_d = ST_OK;
            slot_d   = ptr_x[5:0];
            time_d   = tnew_q;
            sout_d   = runnew_q;
            last_d   = (ptr_x == nlast_q);
          end
          if (ptr_x == cnt_x - XW'(1)) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = S_TRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    nlast_q  <= nlast_d;
    dt_q     <= dt_d;
    ent_q    <= ent_d;
    prod_q   <= prod_d;
    tnew_q   <= tnew_d;
    runnew_q <= runnew_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    time_q   <= time_d;
    sout_q   <= sout_d;
    last_q   <= last_d;
  end

  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign time_out_o  = time_q;
  assign state_out_o = sout_q;
  assign last_o      = last_q;

endmodule
